// ===== rtl/magtrk2_pkg.sv =====
// Shared types and constants for the Track 2 magnetic stripe decoder.
`default_nettype none
package magtrk2_pkg;

  // event kinds
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BIT   = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // decoder phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // special characters
  localparam logic [3:0] SS_CHAR   = 4'hB;
  localparam logic [3:0] FS_CHAR   = 4'hD;
  localparam logic [3:0] ES_CHAR   = 4'hF;
  localparam logic [4:0] SS_WINDOW = 5'h0B;
  localparam logic [4:0] PAN_SAT   = 5'd31;
  localparam logic [2:0] BITS_PER_CHAR = 3'd5;

  // swipe status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SS     = 3'd1;
  localparam logic [2:0] ST_PARITY    = 3'd2;
  localparam logic [2:0] ST_NO_ES     = 3'd3;
  localparam logic [2:0] ST_PAN_BAD   = 3'd4;
  localparam logic [2:0] ST_LRC_BAD   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_PAN   = 2'd0;
  localparam logic [1:0] CFG_MAX_CHARS = 2'd1;

  localparam logic [4:0] MAX_PAN_RST   = 5'd19;
  localparam logic [5:0] MAX_CHARS_RST = 6'd40;

  typedef struct packed {
    logic [1:0] phase;
    logic [4:0] bit_window;
    logic [2:0] bit_count;
    logic [5:0] char_count;
    logic [3:0] lrc_accum;
    logic       parity_failed;
    logic       separator_seen;
    logic [4:0] pan_count;
    logic       lrc_failed;
    logic       end_seen;
  } dec_state_t;

  typedef struct packed {
    logic [4:0] pan_digits;
    logic [2:0] status;
    logic [5:0] char_position;
    logic [3:0] char_value;
    logic       is_status;
  } dec_result_t;

  typedef struct packed {
    logic [4:0] pan_limit;
    logic [5:0] max_track_chars;
  } dec_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/magtrk2_step.sv =====
// Next-state and result logic for one decoder event.
`default_nettype none
module magtrk2_step (
  input  wire  [1:0]                  action,
  input  wire                         data_bit,
  input  magtrk2_pkg::dec_cfg_t       cfg,
  input  magtrk2_pkg::dec_state_t     st,
  output magtrk2_pkg::dec_state_t     st_nxt,
  output logic                        res_valid,
  output magtrk2_pkg::dec_result_t    res
);
  import magtrk2_pkg::*;

  logic [4:0] win_sh;
  logic [2:0] bc_inc;
  logic [3:0] ch;
  logic [2:0] fin_status;

  assign win_sh = {data_bit, st.bit_window[4:1]};
  assign bc_inc = st.bit_count + 3'd1;
  assign ch     = win_sh[3:0];

  always_comb begin
    if (st.phase == PH_HUNT) begin
      fin_status = ST_NO_SS;
    end else if (st.parity_failed) begin
      fin_status = ST_PARITY;
    end else if (!st.end_seen) begin
      fin_status = ST_NO_ES;
    end else if (!st.separator_seen || (st.pan_count > cfg.pan_limit)) begin
      fin_status = ST_PAN_BAD;
    end else if ((st.phase != PH_DONE) || st.lrc_failed) begin
      fin_status = ST_LRC_BAD;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    unique case (action)
      ACT_START: begin
        st_nxt       = '0;
        st_nxt.phase = PH_HUNT;
      end
      ACT_END: begin
        if (st.phase != PH_IDLE) begin
          res_valid      = 1'b1;
          res.is_status  = 1'b1;
          res.status     = fin_status;
          res.pan_digits = st.pan_count;
          st_nxt.phase   = PH_IDLE;
        end
      end
      ACT_BIT: begin
        if (st.phase == PH_HUNT) begin
          st_nxt.bit_window = win_sh;
          if (win_sh == SS_WINDOW) begin
            st_nxt.phase      = PH_READ;
            st_nxt.lrc_accum  = SS_CHAR;
            st_nxt.bit_window = '0;
            st_nxt.bit_count  = '0;
          end
        end else if (st.phase == PH_READ) begin
          if (bc_inc < BITS_PER_CHAR) begin
            st_nxt.bit_window = win_sh;
            st_nxt.bit_count  = bc_inc;
          end else begin
            st_nxt.bit_window = '0;
            st_nxt.bit_count  = '0;
            // odd parity over data and parity bit
            if (!(^win_sh)) begin
              st_nxt.parity_failed = 1'b1;
            end
            if (st.end_seen) begin
              // character after the end sentinel is the LRC
              st_nxt.lrc_failed = (st.lrc_accum != ch);
              st_nxt.phase      = PH_DONE;
            end else if ((ch != ES_CHAR) && (st.char_count >= cfg.max_track_chars)) begin
              st_nxt.phase = PH_DONE;
            end else begin
              st_nxt.lrc_accum = st.lrc_accum ^ ch;
              if (ch == ES_CHAR) begin
                st_nxt.end_seen = 1'b1;
              end else if (!st.separator_seen) begin
                if (ch == FS_CHAR) begin
                  st_nxt.separator_seen = 1'b1;
                end else if (st.pan_count < PAN_SAT) begin
                  st_nxt.pan_count = st.pan_count + 5'd1;
                end
              end
              res_valid         = 1'b1;
              res.char_value    = ch;
              res.char_position = st.char_count;
              st_nxt.char_count = st.char_count + 6'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/magstripe_track2_decoder_top.sv =====
// Top level of the Track 2 magnetic stripe decoder.
`default_nettype none
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: action; tdata: data_bit
// out_     out  out_tvalid/out_tready tuser: is_status; tdata: char/status fields
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One event word is taken per cycle; its effect on the swipe state and its
// result are settled in the same cycle and the result lands in the output
// register, so throughput is one word per cycle.
// The input stalls only when the output register is full and not taken.
// Reset (rst_n low, synchronous) puts the decoder idle and the limits to
// 19 PAN digits and 40 track characters. Configuration is always ready.
module magstripe_track2_decoder_top (
  input  wire         clk,
  input  wire         rst_n,
  // event stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [0] data_bit, [7:1] zero
  input  wire  [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  // [3:0] char_value, [9:4] char_position, [12:10] status,
  // [17:13] pan_digits, [23:18] zero
  output logic [23:0] out_tdata,
  output logic        out_tuser,  // [0] is_status
  // register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [5:0]  cfg_data
);
  import magtrk2_pkg::*;

  dec_cfg_t    cfg_r;
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  logic        res_valid;
  dec_result_t res;
  logic        out_valid_r;
  dec_result_t out_res_r;
  logic        in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // limit registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_limit       <= MAX_PAN_RST;
      cfg_r.max_track_chars <= MAX_CHARS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_PAN:   cfg_r.pan_limit       <= cfg_data[4:0];
        CFG_MAX_CHARS: cfg_r.max_track_chars <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  magtrk2_step u_step (
    .action    (in_tuser),
    .data_bit  (in_tdata[0]),
    .cfg       (cfg_r),
    .st        (state_r),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // swipe state advances on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output register: refilled whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.is_status;
  assign out_tdata  = {6'd0, out_res_r.pan_digits, out_res_r.status,
                       out_res_r.char_position, out_res_r.char_value};

  // a swipe start always opens a fresh hunt
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ACT_START) |=> (state_r.phase == PH_HUNT &&
      state_r.char_count == 6'd0 && state_r.lrc_accum == 4'd0))
    else $error("swipe start did not clear the decoder");

  // a swipe end outside idle yields one status word and returns to idle
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ACT_END && state_r.phase != PH_IDLE) |=>
      (out_tvalid && out_tuser && state_r.phase == PH_IDLE))
    else $error("swipe end gave no status word");

  // once finished, bits leave the state untouched
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ACT_BIT && state_r.phase == PH_DONE) |=> $stable(state_r))
    else $error("bit changed a finished swipe");

endmodule
`default_nettype wire
